FILE: rtl/core/ordered_list_store_top_defines.svh
// assertion macros shared by the checker
`ifndef ORDERED_LIST_STORE_TOP_DEFINES_SVH
`define ORDERED_LIST_STORE_TOP_DEFINES_SVH

// same-cycle implication, masked during reset
`define OLST_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("olst check failed");

// next-cycle implication, masked during reset
`define OLST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("olst check failed");

// next-cycle implication that also holds across reset
`define OLST_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("olst check failed");

`endif

FILE: rtl/core/olst_pkg.sv
package olst_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_APPEND   = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_DUMP_FWD = 2'd2,
        CMD_DUMP_BWD = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                          cmd;
        logic signed [VALUE_WIDTH-1:0] value;
    } t_word;

    typedef struct packed {
        logic  vld;
        logic  is_dump;
        t_word word;
    } t_req;

endpackage

FILE: rtl/core/olst_front.sv
module olst_front
    import olst_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_cmd,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic                          i_ready,
    output t_req                          o_req
);

    t_word               r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QFILL_W-1:0]  r_fill;
    logic [QPTR_W-1:0]   n_wr_ptr;
    logic [QPTR_W-1:0]   n_rd_ptr;
    logic [QFILL_W-1:0]  n_fill;
    logic                push;
    logic                pop;
    t_word               head;

    assign busy = (r_fill == QFILL_W'(QUEUE_DEPTH));
    assign push = start && !busy;
    assign pop  = i_ready && (r_fill != '0);
    assign head = r_queue[r_rd_ptr];

    // classify the word at the head of the queue
    always_comb begin
        o_req.vld     = (r_fill != '0);
        o_req.word    = head;
        o_req.is_dump = (head.cmd == CMD_DUMP_FWD) || (head.cmd == CMD_DUMP_BWD);
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (push && !pop) begin
            n_fill = r_fill + QFILL_W'(1);
        end else if (pop && !push) begin
            n_fill = r_fill - QFILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= '{cmd: t_cmd'(i_cmd), value: i_value};
        end
    end

endmodule

FILE: rtl/core/olst_back.sv
module olst_back
    import olst_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_req                          i_req,
    output logic                          o_ready,
    output logic                          o_strobe,
    output logic                          o_status,
    output logic signed [VALUE_WIDTH-1:0] o_item,
    output logic                          o_is_empty,
    output logic                          o_last
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_SHIFT  = 4'b0100,
        ST_DUMP   = 4'b1000
    } t_state;

    logic signed [VALUE_WIDTH-1:0] r_mem [CAPACITY];
    logic signed [VALUE_WIDTH-1:0] r_rdata;

    t_state                        r_state, n_state;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [CNT_W-1:0]              r_idx, n_idx;
    logic [CNT_W-1:0]              r_cidx, n_cidx;
    logic                          r_cvld, n_cvld;
    logic                          r_fwd, n_fwd;
    logic signed [VALUE_WIDTH-1:0] r_val, n_val;
    logic                          r_stb, n_stb;
    logic                          r_status, n_status;
    logic signed [VALUE_WIDTH-1:0] r_item, n_item;
    logic                          r_empty, n_empty;
    logic                          r_last, n_last;

    logic                          we;
    logic [IDX_W-1:0]              wa;
    logic signed [VALUE_WIDTH-1:0] wd;
    logic [CNT_W-1:0]              rd_pos;
    logic [IDX_W-1:0]              rd_addr;
    logic                          issue;
    logic                          hit;
    logic                          dump_last;

    assign o_ready    = (r_state == ST_IDLE);
    assign o_strobe   = r_stb;
    assign o_status   = r_status;
    assign o_item     = r_item;
    assign o_is_empty = r_empty;
    assign o_last     = r_last;

    assign issue     = (r_idx < r_count);
    assign hit       = r_cvld && (r_rdata == r_val);
    assign dump_last = (r_cidx == r_count - CNT_W'(1));
    assign rd_pos    = (r_state == ST_DUMP && !r_fwd) ? (r_count - CNT_W'(1) - r_idx) : r_idx;
    assign rd_addr   = rd_pos[IDX_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_fwd    = r_fwd;
        n_val    = r_val;
        n_cvld   = 1'b0;
        n_cidx   = r_idx;
        n_stb    = 1'b0;
        n_status = 1'b0;
        n_item   = '0;
        n_empty  = r_empty;
        n_last   = 1'b0;
        we       = 1'b0;
        wa       = r_count[IDX_W-1:0];
        wd       = i_req.word.value;
        case (r_state)
            ST_IDLE: begin
                if (i_req.vld) begin
                    n_val = i_req.word.value;
                    n_fwd = (i_req.word.cmd == CMD_DUMP_FWD);
                    n_idx = '0;
                    if (i_req.is_dump) begin
                        if (r_count == '0) begin
                            n_stb   = 1'b1;
                            n_empty = 1'b1;
                            n_last  = 1'b1;
                        end else begin
                            n_state = ST_DUMP;
                        end
                    end else if (i_req.word.cmd == CMD_REMOVE) begin
                        n_state = ST_SEARCH;
                    end else begin
                        n_stb  = 1'b1;
                        n_last = 1'b1;
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_status = 1'b1;
                            n_empty  = (r_count == '0);
                        end else begin
                            we      = 1'b1;
                            n_count = r_count + CNT_W'(1);
                            n_empty = 1'b0;
                        end
                    end
                end
            end
            ST_SEARCH: begin
                n_cvld = issue;
                if (issue) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (hit) begin
                    n_state = ST_SHIFT;
                end else if (!issue && !r_cvld) begin
                    n_stb   = 1'b1;
                    n_last  = 1'b1;
                    n_empty = (r_count == '0);
                    n_state = ST_IDLE;
                end
            end
            ST_SHIFT: begin
                n_cvld = issue;
                if (issue) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                // move each later entry down by one
                if (r_cvld) begin
                    we = 1'b1;
                    wa = IDX_W'(r_cidx - CNT_W'(1));
                    wd = r_rdata;
                end
                if (!issue && !r_cvld) begin
                    n_count = r_count - CNT_W'(1);
                    n_stb   = 1'b1;
                    n_last  = 1'b1;
                    n_empty = (r_count == CNT_W'(1));
                    n_state = ST_IDLE;
                end
            end
            ST_DUMP: begin
                n_cvld = issue;
                if (issue) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (r_cvld) begin
                    n_stb   = 1'b1;
                    n_item  = r_rdata;
                    n_empty = 1'b0;
                    n_last  = dump_last;
                    if (dump_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_cvld  <= 1'b0;
            r_stb   <= 1'b0;
            r_empty <= 1'b1;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_cvld  <= n_cvld;
            r_stb   <= n_stb;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cidx   <= n_cidx;
        r_fwd    <= n_fwd;
        r_val    <= n_val;
        r_status <= n_status;
        r_item   <= n_item;
        r_last   <= n_last;
    end

    // entry store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rdata <= r_mem[rd_addr];
    end

endmodule

FILE: rtl/core/ordered_list_store_top.sv
// Bounded ordered list of up to 16 signed 32-bit values. A word is taken when
// start is high and busy is low; two words can wait in the input queue, and
// busy rises only when that queue is full. Append answers with one result in
// the cycle after it leaves the queue. Remove scans the list and, on a match,
// moves every later entry down one place through the entry store, one read and
// one write a cycle. A dump of a non-empty list reads one entry a cycle and
// emits one result a cycle with no gaps, the last one flagged.
// Each result shows on the o_ ports for exactly one cycle with o_strobe high
// and cannot be held off, so the receiver must take it in that cycle.
module ordered_list_store_top
    import olst_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_cmd,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_strobe,
    output logic                          o_status,
    output logic signed [VALUE_WIDTH-1:0] o_item,
    output logic                          o_is_empty,
    output logic                          o_last
);

    t_req req;
    logic ready;

    olst_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .i_value (i_value),
        .i_ready (ready),
        .o_req   (req)
    );

    olst_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .o_ready    (ready),
        .o_strobe   (o_strobe),
        .o_status   (o_status),
        .o_item     (o_item),
        .o_is_empty (o_is_empty),
        .o_last     (o_last)
    );

endmodule

FILE: rtl/core/olst_checker.sv
`include "ordered_list_store_top_defines.svh"

module olst_checker
    import olst_pkg::*;
(
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_strobe,
    input logic                          o_status,
    input logic signed [VALUE_WIDTH-1:0] o_item,
    input logic                          o_is_empty,
    input logic                          o_last
);

    // a dump emits its words back to back
    `OLST_ASSERT_NEXT(a_dump_contiguous, i_clk, i_rst_n, o_strobe && !o_last, o_strobe)
    // a refused append is a single final word on a non-empty list
    `OLST_ASSERT_NOW(a_full_single, i_clk, i_rst_n, o_strobe && o_status,
        o_last && !o_is_empty && (o_item == '0))
    // a word that is not the last comes from a dump of a non-empty list
    `OLST_ASSERT_NOW(a_mid_nonempty, i_clk, i_rst_n, o_strobe && !o_last,
        !o_is_empty && !o_status)
    // with no word offered the queue cannot fill up
    `OLST_ASSERT_NEXT(a_busy_needs_word, i_clk, i_rst_n, !start && !busy, !busy)
    // reset leaves no word pending and the queue open
    `OLST_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n, !o_strobe && !busy)

endmodule

bind ordered_list_store_top olst_checker u_olst_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_strobe   (o_strobe),
    .o_status   (o_status),
    .o_item     (o_item),
    .o_is_empty (o_is_empty),
    .o_last     (o_last)
);
